// ----- rtl/sql_statement_splitter_defines.svh -----
// assertion macros used by the statement splitter rtl
`ifndef SQL_STATEMENT_SPLITTER_DEFINES_SVH
`define SQL_STATEMENT_SPLITTER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define SQLSS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sqlss: invariant violated");

// consequence that must hold in the cycle after the antecedent
`define SQLSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sqlss: sequence violated");

`endif

// ----- rtl/sqlss_pkg.sv -----
// types, constants and character classes for the statement splitter
package sqlss_pkg;

    localparam int MAX_TAG   = 32;
    localparam int TAG_LEN_W = $clog2(MAX_TAG + 1);
    localparam int TAG_IDX_W = (MAX_TAG > 1) ? $clog2(MAX_TAG) : 1;
    localparam int BYTE_W    = 8;
    localparam int M_TUSER_W = 6;

    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        RGN_CODE   = 3'd0,
        RGN_SQ     = 3'd1,
        RGN_DQ     = 3'd2,
        RGN_LINE   = 3'd3,
        RGN_BLOCK  = 3'd4,
        RGN_DOLLAR = 3'd5
    } t_region;

    typedef enum logic [10:0] {
        M_CODE   = 11'b000_0000_0001,
        M_SQ     = 11'b000_0000_0010,
        M_DQ     = 11'b000_0000_0100,
        M_LINE   = 11'b000_0000_1000,
        M_BLOCK  = 11'b000_0001_0000,
        M_DOLLAR = 11'b000_0010_0000,
        M_DASH   = 11'b000_0100_0000,
        M_SLASH  = 11'b000_1000_0000,
        M_SQEND  = 11'b001_0000_0000,
        M_STAR   = 11'b010_0000_0000,
        M_TAG    = 11'b100_0000_0000
    } t_lex_mode;

    typedef struct packed {
        t_lex_mode            mode;
        logic                 has_content;
        logic [TAG_LEN_W-1:0] tag_len;
        logic [TAG_LEN_W-1:0] match_pos;
        logic                 cand_ok;
    } t_lex_state;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        t_region           region;
        logic              ends;
        logic              keep;
        logic              ovf;
    } t_lex_result;

    typedef struct packed {
        logic                 en;
        logic [TAG_IDX_W-1:0] addr;
        logic [BYTE_W-1:0]    data;
    } t_tag_wr;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic is_ident(input logic [BYTE_W-1:0] c);
        return is_digit(c) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122) || (c == CH_UNDER);
    endfunction

endpackage

// ----- rtl/sqlss_tag_store.sv -----
// generic ram with one write port and a registered read port
module sqlss_tag_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/sqlss_lexer.sv -----
// next-state and result logic for one script word
module sqlss_lexer (
    input  logic [sqlss_pkg::BYTE_W-1:0] i_byte,
    input  logic                         i_eos,
    input  sqlss_pkg::t_lex_state        i_state,
    input  logic [sqlss_pkg::BYTE_W-1:0] i_tag_rd_data,
    output sqlss_pkg::t_lex_state        o_state,
    output sqlss_pkg::t_lex_result       o_result,
    output sqlss_pkg::t_tag_wr           o_tag_wr
);
    import sqlss_pkg::*;

    localparam logic [TAG_LEN_W-1:0] LEN_MAX  = TAG_LEN_W'(MAX_TAG);
    localparam logic [TAG_LEN_W-1:0] LEN_MAX1 = TAG_LEN_W'(MAX_TAG - 1);
    localparam logic [TAG_LEN_W-1:0] LEN_ONE  = TAG_LEN_W'(1);

    always_comb begin
        t_lex_state           st;
        t_lex_result          res;
        t_tag_wr              wr;
        logic                 hc;
        logic                 do_code;
        logic                 hit;
        logic [TAG_LEN_W-1:0] mnext;

        st      = i_state;
        res     = '0;
        wr      = '0;
        hc      = i_state.has_content;
        do_code = 1'b0;
        hit     = 1'b0;
        mnext   = '0;

        if (i_eos) begin
            // pending dash or slash was a real character
            if (i_state.mode == M_DASH || i_state.mode == M_SLASH) begin
                hc = 1'b1;
            end
            res.ends        = 1'b1;
            res.keep        = hc;
            st.mode         = M_CODE;
            st.has_content  = 1'b0;
            st.tag_len      = '0;
            st.match_pos    = '0;
            st.cand_ok      = 1'b0;
        end else begin
            res.out_byte   = i_byte;
            res.byte_valid = 1'b1;
            res.region     = RGN_CODE;
            case (i_state.mode)
                M_SQ: begin
                    res.region = RGN_SQ;
                    if (i_byte == CH_SQUOTE) st.mode = M_SQEND;
                end
                M_SQEND: begin
                    // doubled quote stays inside the literal
                    if (i_byte == CH_SQUOTE) begin
                        res.region = RGN_SQ;
                        st.mode    = M_SQ;
                    end else begin
                        do_code = 1'b1;
                    end
                end
                M_DQ: begin
                    res.region = RGN_DQ;
                    if (i_byte == CH_DQUOTE) st.mode = M_CODE;
                end
                M_LINE: begin
                    res.region = RGN_LINE;
                    if (i_byte == CH_NL) st.mode = M_CODE;
                end
                M_BLOCK: begin
                    res.region = RGN_BLOCK;
                    if (i_byte == CH_STAR) st.mode = M_STAR;
                end
                M_STAR: begin
                    res.region = RGN_BLOCK;
                    if (i_byte == CH_SLASH) st.mode = M_CODE;
                    else if (i_byte != CH_STAR) st.mode = M_BLOCK;
                end
                M_DASH: begin
                    if (i_byte == CH_DASH) begin
                        res.region = RGN_LINE;
                        st.mode    = M_LINE;
                    end else begin
                        hc      = 1'b1;
                        do_code = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (i_byte == CH_STAR) begin
                        res.region = RGN_BLOCK;
                        st.mode    = M_BLOCK;
                    end else begin
                        hc      = 1'b1;
                        do_code = 1'b1;
                    end
                end
                M_TAG: begin
                    if (is_ident(i_byte)) begin
                        if (i_state.cand_ok) begin
                            if (i_state.tag_len == LEN_ONE && is_digit(i_byte)) begin
                                st.cand_ok = 1'b0;
                            end else if (i_state.tag_len >= LEN_MAX1) begin
                                // room is needed for the closing dollar too
                                st.cand_ok = 1'b0;
                                res.ovf    = 1'b1;
                            end else begin
                                wr.en      = 1'b1;
                                wr.addr    = i_state.tag_len[TAG_IDX_W-1:0];
                                wr.data    = i_byte;
                                st.tag_len = i_state.tag_len + LEN_ONE;
                            end
                        end
                    end else if (i_byte == CH_DOLLAR && i_state.cand_ok &&
                                 i_state.tag_len < LEN_MAX) begin
                        wr.en        = 1'b1;
                        wr.addr      = i_state.tag_len[TAG_IDX_W-1:0];
                        wr.data      = CH_DOLLAR;
                        st.tag_len   = i_state.tag_len + LEN_ONE;
                        st.match_pos = '0;
                        st.mode      = M_DOLLAR;
                        res.region   = RGN_DOLLAR;
                    end else begin
                        do_code = 1'b1;
                    end
                end
                M_DOLLAR: begin
                    res.region = RGN_DOLLAR;
                    hit = (i_state.match_pos < i_state.tag_len) &&
                          (i_state.match_pos < LEN_MAX) &&
                          (i_tag_rd_data == i_byte);
                    if (hit) begin
                        mnext = i_state.match_pos + LEN_ONE;
                    end else if (i_byte == CH_DOLLAR) begin
                        mnext = LEN_ONE;
                    end else begin
                        mnext = '0;
                    end
                    if (mnext >= i_state.tag_len) begin
                        st.match_pos = '0;
                        st.mode      = M_CODE;
                    end else begin
                        st.match_pos = mnext;
                    end
                end
                default: begin
                    do_code = 1'b1;
                end
            endcase

            if (do_code) begin
                res.region = RGN_CODE;
                if (i_byte == CH_SQUOTE) begin
                    st.mode    = M_SQ;
                    hc         = 1'b1;
                    res.region = RGN_SQ;
                end else if (i_byte == CH_DQUOTE) begin
                    st.mode    = M_DQ;
                    hc         = 1'b1;
                    res.region = RGN_DQ;
                end else if (i_byte == CH_DASH) begin
                    st.mode = M_DASH;
                end else if (i_byte == CH_SLASH) begin
                    st.mode = M_SLASH;
                end else if (i_byte == CH_DOLLAR) begin
                    hc         = 1'b1;
                    wr.en      = 1'b1;
                    wr.addr    = '0;
                    wr.data    = CH_DOLLAR;
                    st.tag_len = LEN_ONE;
                    st.cand_ok = 1'b1;
                    st.mode    = M_TAG;
                end else if (i_byte == CH_SEMI) begin
                    res.ends = 1'b1;
                    res.keep = hc;
                    hc       = 1'b0;
                    st.mode  = M_CODE;
                end else begin
                    st.mode = M_CODE;
                    if (!is_space(i_byte)) hc = 1'b1;
                end
            end
            st.has_content = hc;
        end

        o_state  = st;
        o_result = res;
        o_tag_wr = wr;
    end

endmodule

// ----- rtl/sql_statement_splitter.sv -----
// Streaming SQL statement splitter. Script bytes enter on the slave side one
// word per cycle while the master side is ready and leave on the master side
// unchanged, each tagged with its lexical region (code, single-quoted text,
// double-quoted identifier, line comment, block comment, dollar-quoted body).
// A top-level ';' or an end-of-script word (tuser set) raises tlast, and tuser
// bit 4 then says whether the statement held anything besides whitespace and
// comments. A dollar delimiter longer than MAX_TAG bytes is not an opener and
// flags tag_overflow on the byte that overruns it. Throughput is one word per
// clock with no gaps while the master side is ready; a word passes through the
// input register and the result register on its way to the master side. The
// rate is set by the lexer loop: the state registers and the registered read
// of the delimiter store, addressed with the match position that the next word
// will use, are updated together for each word. The delimiter store needs no
// clearing after reset, so words are taken from the first cycle out of reset.
module sql_statement_splitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [sqlss_pkg::BYTE_W-1:0]    i_s_axis_tdata,   // [7:0] data_byte
    input  logic                            i_s_axis_tuser,   // [0] end_of_script
    // master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [sqlss_pkg::BYTE_W-1:0]    o_m_axis_tdata,   // [7:0] out_byte
    output logic                            o_m_axis_tlast,   // ends_statement
    output logic [sqlss_pkg::M_TUSER_W-1:0] o_m_axis_tuser    // [0] byte_valid,
                                                              // [3:1] region,
                                                              // [4] keep_statement,
                                                              // [5] tag_overflow
);
    import sqlss_pkg::*;

    `include "sql_statement_splitter_defines.svh"

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eos;

    // lexer state
    t_lex_state r_state;
    t_lex_state n_state;

    // result register
    logic        r_out_valid;
    t_lex_result r_out;
    t_lex_result w_result;

    t_tag_wr              w_tag_wr;
    t_tag_wr              w_tag_wr_gated;
    logic [TAG_IDX_W-1:0] w_tag_rd_addr;
    logic [BYTE_W-1:0]    w_tag_rd_data;

    logic w_adv;   // result register can take a word this cycle
    logic w_fire;  // input register word is processed this cycle
    logic w_take;  // slave handshake

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_eos  <= i_s_axis_tuser;
        end
    end

    // read address tracks the match position the state register will hold,
    // so the stored byte is ready when the next word reaches the lexer
    assign w_tag_rd_addr = w_fire ? n_state.match_pos[TAG_IDX_W-1:0] :
                                    r_state.match_pos[TAG_IDX_W-1:0];

    // delimiter store
    sqlss_tag_store #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_TAG)
    ) u_tag_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_tag_wr_gated.en),
        .i_wr_addr (w_tag_wr_gated.addr),
        .i_wr_data (w_tag_wr_gated.data),
        .i_rd_addr (w_tag_rd_addr),
        .o_rd_data (w_tag_rd_data)
    );

    sqlss_lexer u_lexer (
        .i_byte        (r_in_byte),
        .i_eos         (r_in_eos),
        .i_state       (r_state),
        .i_tag_rd_data (w_tag_rd_data),
        .o_state       (n_state),
        .o_result      (w_result),
        .o_tag_wr      (w_tag_wr)
    );

    always_comb begin
        w_tag_wr_gated    = w_tag_wr;
        w_tag_wr_gated.en = w_tag_wr.en && w_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode        <= M_CODE;
            r_state.has_content <= 1'b0;
            r_state.tag_len     <= '0;
            r_state.match_pos   <= '0;
            r_state.cand_ok     <= 1'b0;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.out_byte;
    assign o_m_axis_tlast  = r_out.ends;
    assign o_m_axis_tuser  = {r_out.ovf, r_out.keep, r_out.region, r_out.byte_valid};

    // stored delimiter never exceeds the store
    `SQLSS_ASSERT_ALWAYS(a_tag_len_bound, r_state.tag_len <= TAG_LEN_W'(MAX_TAG))
    // inside a dollar body the partial match is always short of the delimiter
    `SQLSS_ASSERT_ALWAYS(a_match_short,
        (r_state.mode != M_DOLLAR) || (r_state.match_pos < r_state.tag_len))
    // end of script returns the lexer to a clean code state
    `SQLSS_ASSERT_NEXT(a_eos_clears, w_fire && r_in_eos,
        (r_state.mode == M_CODE) && !r_state.has_content && (r_state.tag_len == '0))
    // an end-of-script word always closes a statement
    `SQLSS_ASSERT_ALWAYS(a_eos_ends, !r_out_valid || r_out.byte_valid || r_out.ends)

endmodule
